// ----- hdl/itrs_pkg.sv -----
package itrs_pkg;

	// Radix limits and special radix
	localparam int RADIX_MIN = 2;
	localparam int RADIX_MAX = 36;
	localparam int RADIX_DEC = 10;

	// ASCII mapping
	localparam logic [6:0] CHAR_MINUS = 7'h2D;
	localparam logic [6:0] CHAR_NONE  = 7'h00;
	localparam int ASCII_DIGIT_BASE   = 48;
	localparam int ASCII_ALPHA_BASE   = 55;
	localparam int DIGIT_DEC_LIMIT    = 10;

	// Divider iteration count, one quotient bit per cycle
	localparam int DIV_BITS = 32;

	// Classified item held in the front queue
	typedef struct packed {
		logic        bad;
		logic        neg;
		logic [31:0] mag;
		logic [5:0]  radix;
	} item_t;

	// Divider request
	typedef struct packed {
		logic        load;
		logic [31:0] dividend;
		logic [5:0]  divisor;
	} div_req_t;

	// Divider result
	typedef struct packed {
		logic        done;
		logic [31:0] quot;
		logic [5:0]  rem;
	} div_res_t;

	// Digit value to ASCII
	function automatic logic [6:0] ascii_of(input logic [5:0] d);
		logic [6:0] d7;
		d7 = {1'b0, d};
		if (d < 6'(DIGIT_DEC_LIMIT))
			ascii_of = 7'(ASCII_DIGIT_BASE) + d7;
		else
			ascii_of = 7'(ASCII_ALPHA_BASE) + d7;
	endfunction

endpackage

// ----- hdl/itrs_front.sv -----
module itrs_front (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic signed [31:0]   value,
	input  logic [5:0]           radix,
	output logic                 busy,
	input  logic                 pop,
	output logic                 head_vld,
	output itrs_pkg::item_t      head
);

	itrs_pkg::item_t cls;
	itrs_pkg::item_t slot_q [2];
	logic            wr_ptr_q;
	logic            rd_ptr_q;
	logic [1:0]      count_q;
	logic            push;
	logic            do_pop;
	logic [31:0]     value_u;

	// Classify the incoming item
	always_comb begin
		value_u   = $unsigned(value);
		cls.bad   = (radix < 6'(itrs_pkg::RADIX_MIN)) || (radix > 6'(itrs_pkg::RADIX_MAX));
		cls.neg   = (radix == 6'(itrs_pkg::RADIX_DEC)) && value_u[31];
		cls.mag   = cls.neg ? (32'd0 - value_u) : value_u;
		cls.radix = radix;
	end

	assign busy     = (count_q == 2'd2);
	assign push     = start && !busy;
	assign head_vld = (count_q != 2'd0);
	assign do_pop   = pop && head_vld;
	assign head     = slot_q[rd_ptr_q];

	// Two-entry queue control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (do_pop)
				rd_ptr_q <= ~rd_ptr_q;
			case ({push, do_pop})
				2'b10:   count_q <= count_q + 2'd1;
				2'b01:   count_q <= count_q - 2'd1;
				default: count_q <= count_q;
			endcase
		end
	end

	// Queue payload
	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= cls;
	end

endmodule

// ----- hdl/itrs_div.sv -----
module itrs_div (
	input  logic                 clk,
	input  logic                 arst_n,
	input  itrs_pkg::div_req_t   req,
	output itrs_pkg::div_res_t   res
);

	logic [31:0] q_q;
	logic [5:0]  rem_q;
	logic [5:0]  divisor_q;
	logic [4:0]  bit_q;
	logic        active_q;
	logic        done_q;
	logic [6:0]  trial;
	logic        ge;
	logic [6:0]  diff;

	// One restoring step per cycle
	always_comb begin
		trial = {rem_q, q_q[31]};
		ge    = (trial >= {1'b0, divisor_q});
		diff  = ge ? (trial - {1'b0, divisor_q}) : trial;
	end

	// Control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0;
			done_q   <= 1'b0;
			bit_q    <= 5'd0;
		end else begin
			done_q <= 1'b0;
			if (req.load) begin
				active_q <= 1'b1;
				bit_q    <= 5'd0;
			end else if (active_q) begin
				bit_q <= bit_q + 5'd1;
				if (bit_q == 5'(itrs_pkg::DIV_BITS - 1)) begin
					active_q <= 1'b0;
					done_q   <= 1'b1;
				end
			end
		end
	end

	// Datapath
	always_ff @(posedge clk) begin
		if (req.load) begin
			q_q       <= req.dividend;
			rem_q     <= 6'd0;
			divisor_q <= req.divisor;
		end else if (active_q) begin
			q_q   <= {q_q[30:0], ge};
			rem_q <= diff[5:0];
		end
	end

	assign res.done = done_q;
	assign res.quot = q_q;
	assign res.rem  = rem_q;

endmodule

// ----- hdl/itrs_back.sv -----
module itrs_back #(
	parameter int DIGIT_SLOTS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 head_vld,
	input  itrs_pkg::item_t      head,
	output logic                 pop,
	output itrs_pkg::div_req_t   div_req,
	input  itrs_pkg::div_res_t   div_res,
	output logic                 strobe,
	output logic [6:0]           character,
	output logic                 last,
	output logic                 bad_base
);

	localparam int IW = $clog2(DIGIT_SLOTS);
	localparam int CW = $clog2(DIGIT_SLOTS + 1);

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_DIV  = 4'b0010,
		ST_SIGN = 4'b0100,
		ST_EMIT = 4'b1000
	} back_state_t;

	back_state_t state_q;
	logic [CW-1:0] cnt_q;
	logic [CW-1:0] cnt_inc;
	logic [IW-1:0] idx_q;
	logic          neg_q;
	logic [5:0]    radix_q;
	logic          out_vld_q;
	logic          out_sel_digit_q;
	logic [6:0]    out_char_q;
	logic          out_last_q;
	logic          out_bad_q;
	logic [5:0]    rd_data_q;
	logic [5:0]    stack_mem [DIGIT_SLOTS];
	logic          stack_we;
	logic          rd_en;
	logic          digits_done;

	assign cnt_inc     = cnt_q + CW'(1);
	assign digits_done = (div_res.quot == 32'd0) || (cnt_inc == CW'(DIGIT_SLOTS));
	assign stack_we    = (state_q == ST_DIV) && div_res.done;
	assign rd_en       = (state_q == ST_EMIT);
	assign pop         = (state_q == ST_IDLE) && head_vld;

	// Divider requests: first digit from the queue head, later ones from the quotient
	always_comb begin
		div_req.load     = 1'b0;
		div_req.dividend = head.mag;
		div_req.divisor  = head.radix;
		if (pop && !head.bad) begin
			div_req.load = 1'b1;
		end else if (stack_we && !digits_done) begin
			div_req.load     = 1'b1;
			div_req.dividend = div_res.quot;
			div_req.divisor  = radix_q;
		end
	end

	// Sequencer and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= ST_IDLE;
			cnt_q           <= '0;
			idx_q           <= '0;
			neg_q           <= 1'b0;
			radix_q         <= 6'd0;
			out_vld_q       <= 1'b0;
			out_sel_digit_q <= 1'b0;
			out_char_q      <= itrs_pkg::CHAR_NONE;
			out_last_q      <= 1'b0;
			out_bad_q       <= 1'b0;
		end else begin
			out_vld_q <= 1'b0;
			case (state_q)
				ST_IDLE: begin
					if (head_vld) begin
						if (head.bad) begin
							out_vld_q       <= 1'b1;
							out_sel_digit_q <= 1'b0;
							out_char_q      <= itrs_pkg::CHAR_NONE;
							out_last_q      <= 1'b1;
							out_bad_q       <= 1'b1;
						end else begin
							neg_q   <= head.neg;
							radix_q <= head.radix;
							cnt_q   <= '0;
							state_q <= ST_DIV;
						end
					end
				end
				ST_DIV: begin
					if (div_res.done) begin
						cnt_q <= cnt_inc;
						if (digits_done) begin
							idx_q   <= cnt_q[IW-1:0];
							state_q <= neg_q ? ST_SIGN : ST_EMIT;
						end
					end
				end
				ST_SIGN: begin
					out_vld_q       <= 1'b1;
					out_sel_digit_q <= 1'b0;
					out_char_q      <= itrs_pkg::CHAR_MINUS;
					out_last_q      <= 1'b0;
					out_bad_q       <= 1'b0;
					state_q         <= ST_EMIT;
				end
				ST_EMIT: begin
					out_vld_q       <= 1'b1;
					out_sel_digit_q <= 1'b1;
					out_last_q      <= (idx_q == '0);
					out_bad_q       <= 1'b0;
					if (idx_q == '0)
						state_q <= ST_IDLE;
					else
						idx_q <= idx_q - IW'(1);
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Digit stack write, least significant digit first
	always_ff @(posedge clk) begin
		if (stack_we)
			stack_mem[cnt_q[IW-1:0]] <= div_res.rem;
	end

	// Digit stack read, most significant first
	always_ff @(posedge clk) begin
		if (rd_en)
			rd_data_q <= stack_mem[idx_q];
	end

	assign strobe    = out_vld_q;
	assign character = out_sel_digit_q ? itrs_pkg::ascii_of(rd_data_q) : out_char_q;
	assign last      = out_last_q;
	assign bad_base  = out_bad_q;

	// Divider only finishes while a conversion is dividing
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (state_q == ST_DIV))
		else $error("divider done outside digit loop");

	// Remainder is a legal digit of the current radix
	a_rem_range: assert property (@(posedge clk) disable iff (!arst_n)
		div_res.done |-> (div_res.rem < radix_q))
		else $error("remainder not below radix");

	// Digit count never passes the stack depth
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= CW'(DIGIT_SLOTS))
		else $error("digit count beyond stack depth");

	// Sign state puts a minus on the output in the next cycle
	a_sign_out: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SIGN) |=> (out_vld_q && !out_sel_digit_q
			&& (out_char_q == itrs_pkg::CHAR_MINUS) && !out_last_q))
		else $error("minus not emitted after sign state");

	// A queue head taken with a legal radix starts the digit loop
	a_pop_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(pop && !head.bad) |=> (state_q == ST_DIV))
		else $error("accepted conversion did not enter digit loop");

endmodule

// ----- hdl/integer_to_radix_string.sv -----
// A bad radix gives its single result, with last and bad_base high, and no division; a valid
// conversion of d digits gives its characters, an optional '-' first, after its d divisions.
// Items are converted one at a time: the back end takes the next queued item only after it has
// issued the last character of the current one; the bit-serial divider, run once per digit, sets the pace.
// A two-entry queue takes new items during a conversion; busy is high while it is full.
// Reset: arst_n clears all control state at once; no clearing pass. Results are strobed.
module integer_to_radix_string #(
	parameter int DIGIT_SLOTS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  logic signed [31:0]   value,
	input  logic [5:0]           radix,
	output logic                 strobe,
	output logic [6:0]           character,
	output logic                 last,
	output logic                 bad_base
);

	logic               head_vld;
	itrs_pkg::item_t    head;
	logic               pop;
	itrs_pkg::div_req_t div_req;
	itrs_pkg::div_res_t div_res;

	// Front: classify and queue
	itrs_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (start),
		.value    (value),
		.radix    (radix),
		.busy     (busy),
		.pop      (pop),
		.head_vld (head_vld),
		.head     (head)
	);

	// Bit-serial divider, used by the back end for every digit
	itrs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.res    (div_res)
	);

	// Back: digit loop, stack and emit
	itrs_back #(
		.DIGIT_SLOTS (DIGIT_SLOTS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head_vld  (head_vld),
		.head      (head),
		.pop       (pop),
		.div_req   (div_req),
		.div_res   (div_res),
		.strobe    (strobe),
		.character (character),
		.last      (last),
		.bad_base  (bad_base)
	);

endmodule

// ----- sim/integer_to_radix_string_tb.sv -----
`timescale 1ns / 1ps

module integer_to_radix_string_tb;

	// Longest stretch with no transfer on either side before giving up
	localparam int STALL_LIMIT = 12000;
	localparam int RANDOM_ITEMS = 300;
	localparam int SETTLE_CYCLES = 40;

	// One number to convert, with its lead-in gap
	typedef struct {
		logic signed [31:0] num;
		logic [5:0]         base;
		int unsigned        gap;
		bit                 drain;
	} number_req_t;

	// One expected character
	typedef struct packed {
		logic [6:0] ch;
		logic       last;
		logic       bad;
	} char_exp_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic signed [31:0] value = '0;
	logic [5:0]         radix = '0;
	logic               busy;
	logic               strobe;
	logic [6:0]         character;
	logic               last;
	logic               bad_base;

	number_req_t numbers_todo[$];
	char_exp_t   chars_due[$];
	int unsigned numbers_queued = 0;
	int unsigned numbers_taken = 0;
	int unsigned error_count = 0;
	int unsigned stall_cycles = 0;

	// Driver-private state
	number_req_t staged_req;
	bit          staged = 1'b0;
	int unsigned gap_left = 0;

	integer_to_radix_string u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.value     (value),
		.radix     (radix),
		.strobe    (strobe),
		.character (character),
		.last      (last),
		.bad_base  (bad_base)
	);

	initial begin
		forever #1 clk = ~clk;
	end

	task automatic report_mismatch(input string what);
		$display("integer_to_radix_string_tb: mismatch at %0t: %s", $realtime, what);
		error_count++;
	endtask

	// Expand one number into the characters it should produce
	function automatic void expand_digits(input logic signed [31:0] num, input logic [5:0] base);
		logic [31:0] quot;
		logic [5:0]  digs [32];
		int          n;
		bit          neg;
		char_exp_t   e;
		if (base < itrs_pkg::RADIX_MIN || base > itrs_pkg::RADIX_MAX) begin
			e.ch = itrs_pkg::CHAR_NONE;
			e.last = 1'b1;
			e.bad = 1'b1;
			chars_due.push_back(e);
			return;
		end
		quot = num;
		neg = (base == itrs_pkg::RADIX_DEC) && num[31];
		if (neg)
			quot = 32'd0 - quot;
		n = 0;
		// Digits come out least significant first
		do begin
			digs[n] = 6'(quot % {26'd0, base});
			n++;
			quot = quot / {26'd0, base};
		end while (quot != 0 && n < 32);
		if (neg) begin
			e.ch = itrs_pkg::CHAR_MINUS;
			e.last = 1'b0;
			e.bad = 1'b0;
			chars_due.push_back(e);
		end
		for (int i = n - 1; i >= 0; i--) begin
			if (digs[i] < 6'(itrs_pkg::DIGIT_DEC_LIMIT))
				e.ch = 7'(itrs_pkg::ASCII_DIGIT_BASE + digs[i]);
			else
				e.ch = 7'(itrs_pkg::ASCII_ALPHA_BASE + digs[i]);
			e.last = (i == 0);
			e.bad = 1'b0;
			chars_due.push_back(e);
		end
	endfunction

	task automatic queue_number(input logic signed [31:0] num, input logic [5:0] base,
			input int unsigned gap, input bit drain);
		number_req_t r;
		r.num = num;
		r.base = base;
		r.gap = gap;
		r.drain = drain;
		numbers_todo.push_back(r);
		numbers_queued++;
	endtask

	function automatic logic [31:0] pick_value();
		case ($urandom_range(0, 5))
			0: return $urandom;
			1: return 32'($urandom_range(0, 40));
			2: return -32'($urandom_range(1, 40));
			3: begin
				case ($urandom_range(0, 3))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'hFFFF_FFFF;
					default: return 32'd1;
				endcase
			end
			default: return $urandom >> $urandom_range(0, 31);
		endcase
	endfunction

	function automatic logic [5:0] pick_radix();
		case ($urandom_range(0, 9))
			0: return 6'($urandom_range(0, 63));
			1, 2: return 6'(itrs_pkg::RADIX_DEC);
			3: return ($urandom_range(0, 1) != 0) ? 6'(itrs_pkg::RADIX_MIN)
				: 6'(itrs_pkg::RADIX_MAX);
			default: return 6'($urandom_range(itrs_pkg::RADIX_MIN, itrs_pkg::RADIX_MAX));
		endcase
	endfunction

	// Driver: present staged numbers, honor gaps and drain pauses
	always @(posedge clk) begin
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy) begin
				expand_digits(value, radix);
				numbers_taken++;
			end
			if (!start || !busy) begin
				if (!staged && numbers_todo.size() != 0) begin
					staged_req = numbers_todo.pop_front();
					staged = 1'b1;
					gap_left = staged_req.gap;
				end
				if (staged && gap_left == 0 && !(staged_req.drain && chars_due.size() != 0)) begin
					start <= 1'b1;
					value <= staged_req.num;
					radix <= staged_req.base;
					staged = 1'b0;
				end else begin
					start <= 1'b0;
					if (staged && gap_left != 0)
						gap_left--;
				end
			end
		end
	end

	// Monitor: check every strobed character against the oldest expectation
	always @(posedge clk) begin
		char_exp_t e;
		if (arst_n && strobe) begin
			if (chars_due.size() == 0) begin
				report_mismatch($sformatf("unexpected char 0x%02h last %b bad %b",
					character, last, bad_base));
			end else begin
				e = chars_due.pop_front();
				if (character !== e.ch)
					report_mismatch($sformatf("character 0x%02h, want 0x%02h", character, e.ch));
				if (last !== e.last)
					report_mismatch($sformatf("last %b, want %b", last, e.last));
				if (bad_base !== e.bad)
					report_mismatch($sformatf("bad_base %b, want %b", bad_base, e.bad));
			end
		end
	end

	// Watchdog on cycles with no transfer
	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || strobe)
				stall_cycles <= 0;
			else
				stall_cycles <= stall_cycles + 1;
			if (stall_cycles >= STALL_LIMIT) begin
				$display("integer_to_radix_string_tb: errors");
				$finish;
			end
		end
	end

	initial begin
		bit burst;
		int unsigned gap;
		// Directed: extremes, zero, sign handling, bad radix, longest string
		queue_number(32'sd0, 6'(itrs_pkg::RADIX_DEC), 0, 1'b0);
		queue_number(32'sd0, 6'(itrs_pkg::RADIX_MIN), 0, 1'b0);
		queue_number(-32'sd1, 6'(itrs_pkg::RADIX_DEC), 0, 1'b0);
		queue_number(32'sh8000_0000, 6'(itrs_pkg::RADIX_DEC), 0, 1'b0);
		queue_number(32'sh7FFF_FFFF, 6'(itrs_pkg::RADIX_DEC), 0, 1'b0);
		queue_number(-32'sd1, 6'(itrs_pkg::RADIX_MIN), 0, 1'b0);
		queue_number(32'sh8000_0000, 6'(itrs_pkg::RADIX_MIN), 0, 1'b0);
		queue_number(32'sd0, 6'd0, 0, 1'b0);
		queue_number(32'sd5, 6'd1, 0, 1'b0);
		queue_number(-32'sd9, 6'(itrs_pkg::RADIX_MAX + 1), 0, 1'b0);
		queue_number(32'sh7FFF_FFFF, 6'd63, 0, 1'b0);
		queue_number(32'sd35, 6'(itrs_pkg::RADIX_MAX), 3, 1'b0);
		queue_number(32'sh7FFF_FFFF, 6'(itrs_pkg::RADIX_MAX), 0, 1'b0);
		queue_number(-32'sd1, 6'(itrs_pkg::RADIX_MAX), 0, 1'b0);
		queue_number(-32'sd5, 6'd16, 0, 1'b1);
		queue_number(32'sd10, 6'd16, 0, 1'b0);
		queue_number(32'sd9, 6'(itrs_pkg::RADIX_DEC), 0, 1'b0);
		queue_number(-32'sd7, 6'd3, 2, 1'b0);
		queue_number(-32'sd12345, 6'(itrs_pkg::RADIX_DEC), 0, 1'b0);
		queue_number(32'sd12345, 6'(itrs_pkg::RADIX_MAX), 0, 1'b1);
		// Random: mixed values and radices, bursts with no gaps between them
		burst = 1'b0;
		for (int k = 0; k < RANDOM_ITEMS; k++) begin
			if (k % 20 == 0)
				burst = ($urandom_range(0, 3) == 0);
			gap = burst ? 0 : $urandom_range(0, 8);
			queue_number(pick_value(), pick_radix(), gap, $urandom_range(0, 49) == 0);
		end

		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		while (numbers_taken < numbers_queued)
			@(posedge clk);
		while (chars_due.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (error_count == 0)
			$display("integer_to_radix_string_tb: clean");
		else
			$display("integer_to_radix_string_tb: errors");
		$finish;
	end

endmodule

// ----- files.f -----
hdl/itrs_pkg.sv
hdl/itrs_front.sv
hdl/itrs_div.sv
hdl/itrs_back.sv
hdl/integer_to_radix_string.sv
sim/integer_to_radix_string_tb.sv
